// ===== hdl/sstod_pkg.sv =====
// Package for the serial-set time-of-day clock.
// Holds the command codes, queue entry layout, character constants and the
// decimal split helper shared by the front, queue and back modules.
`default_nettype none

package sstod_pkg;

   // Line buffer defaults and layout
   localparam int LINE_CAPACITY_DEFAULT = 10;
   localparam int PARSE_LEN             = 8;   // characters HH?MM?SS
   localparam int LINE_IDX_W            = $clog2(PARSE_LEN);
   localparam int QUEUE_DEPTH           = 2;

   // Item selector on req_tuser
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_BYTE = 1'b1;

   // Characters
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_RED_ON    = 8'h52;  // R
   localparam logic [7:0] CHAR_RED_OFF   = 8'h58;  // X
   localparam logic [7:0] CHAR_GREEN_ON  = 8'h47;  // G
   localparam logic [7:0] CHAR_GREEN_OFF = 8'h59;  // Y
   localparam logic [7:0] CHAR_BLUE_ON   = 8'h42;  // B
   localparam logic [7:0] CHAR_BLUE_OFF  = 8'h5A;  // Z

   // Lamp bit masks
   localparam logic [2:0] LAMP_RED   = 3'b001;
   localparam logic [2:0] LAMP_BLUE  = 3'b010;
   localparam logic [2:0] LAMP_GREEN = 3'b100;

   // Time limits
   localparam logic [5:0] MINUTE_SECONDS = 6'd60;
   localparam logic [4:0] DAY_HOURS      = 5'd24;
   localparam logic [3:0] OFFSET_RESET   = 4'd2;

   // What the back end must do with a queued beat
   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_BYTE,
      CMD_SET,
      CMD_REJECT
   } cmd_kind_type;

   // Normalised time of day
   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } tod_type;

   // Front-to-back queue entry
   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0]   lamps;
      tod_type      set_time;  // meaningful for CMD_SET only
   } cmd_type;

   // Split a value 0..59 into {tens[2:0], ones[3:0]}
   function automatic logic [6:0] split_dec(input logic [5:0] v);
      logic [2:0] tens;
      logic [5:0] rest;
      begin
         priority if (v >= 6'd50) begin
            tens = 3'd5; rest = v - 6'd50;
         end else if (v >= 6'd40) begin
            tens = 3'd4; rest = v - 6'd40;
         end else if (v >= 6'd30) begin
            tens = 3'd3; rest = v - 6'd30;
         end else if (v >= 6'd20) begin
            tens = 3'd2; rest = v - 6'd20;
         end else if (v >= 6'd10) begin
            tens = 3'd1; rest = v - 6'd10;
         end else begin
            tens = 3'd0; rest = v;
         end
         split_dec = {tens, rest[3:0]};
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sstod_front.sv =====
// Front end: accepts stream beats, keeps the line buffer and lamp bits,
// classifies each beat and parses a closed line. Depends on sstod_pkg.
`default_nettype none

module sstod_front import sstod_pkg::*; #(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   input  wire logic       req_tuser,   // [0] operation
   output logic            push_valid,
   output cmd_type         push_cmd,
   input  wire logic       queue_full
);

   localparam int POS_W       = $clog2(LINE_CAPACITY);
   localparam int STORE_DEPTH = LINE_CAPACITY - 1;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [2:0]       lamp_ff, lamp_in;
   logic [7:0]       line_ff [PARSE_LEN];

   logic accept, is_byte, full, close, store, write_line;
   logic [7:0] first_char;

   // parse signals
   logic       digits_ok, time_ok;
   logic [6:0] raw_h, raw_m, raw_s;
   logic [6:0] sum_m, sum_h, norm_s, norm_m;
   logic       carry_s, carry_m;

   function automatic logic [2:0] apply_lamp(input logic [2:0] lamps, input logic [7:0] c);
      logic [2:0] res;
      begin
         res = lamps;
         unique case (c)
            CHAR_RED_ON:    res = lamps | LAMP_RED;
            CHAR_RED_OFF:   res = lamps & ~LAMP_RED;
            CHAR_GREEN_ON:  res = lamps | LAMP_GREEN;
            CHAR_GREEN_OFF: res = lamps & ~LAMP_GREEN;
            CHAR_BLUE_ON:   res = lamps | LAMP_BLUE;
            CHAR_BLUE_OFF:  res = lamps & ~LAMP_BLUE;
            default:        res = lamps;
         endcase
         apply_lamp = res;
      end
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // two digits to a binary value 0..99
   function automatic logic [6:0] pair_val(input logic [7:0] t, input logic [7:0] o);
      logic [6:0] tv;
      begin
         tv       = {3'b000, t[3:0]};
         pair_val = (tv << 3) + (tv << 1) + {3'b000, o[3:0]};
      end
   endfunction

   // Classify the beat on the port
   always_comb begin
      req_tready = !queue_full;
      accept     = req_tvalid && req_tready;
      is_byte    = req_tuser == OP_BYTE;
      full       = pos_ff == POS_W'(STORE_DEPTH);
      close      = is_byte && ((req_tdata == CHAR_NEWLINE) || full);
      store      = is_byte && !close;
      write_line = accept && store && (pos_ff < POS_W'(PARSE_LEN));
      first_char = (pos_ff == '0) ? req_tdata : line_ff[0];
   end

   // Parse the stored line as HH?MM?SS and fold minute/second overflow
   always_comb begin
      digits_ok = is_digit(line_ff[0]) && is_digit(line_ff[1]) &&
                  is_digit(line_ff[3]) && is_digit(line_ff[4]) &&
                  is_digit(line_ff[6]) && is_digit(line_ff[7]);
      raw_h   = pair_val(line_ff[0], line_ff[1]);
      raw_m   = pair_val(line_ff[3], line_ff[4]);
      raw_s   = pair_val(line_ff[6], line_ff[7]);
      carry_s = raw_s >= 7'(MINUTE_SECONDS);
      norm_s  = carry_s ? raw_s - 7'(MINUTE_SECONDS) : raw_s;
      sum_m   = raw_m + {6'b0, carry_s};
      carry_m = sum_m >= 7'(MINUTE_SECONDS);
      norm_m  = carry_m ? sum_m - 7'(MINUTE_SECONDS) : sum_m;
      sum_h   = raw_h + {6'b0, carry_m};
      time_ok = (pos_ff >= POS_W'(PARSE_LEN)) && digits_ok && (sum_h < 7'(DAY_HOURS));
   end

   // Next state and queue entry
   always_comb begin
      pos_in  = pos_ff;
      lamp_in = lamp_ff;
      if (accept && close) begin
         pos_in = '0;
      end else if (accept && store) begin
         pos_in  = pos_ff + 1'b1;
         lamp_in = apply_lamp(lamp_ff, first_char);
      end
      push_valid = accept;
      push_cmd.lamps            = lamp_in;
      push_cmd.set_time.hours   = sum_h[4:0];
      push_cmd.set_time.minutes = norm_m[5:0];
      push_cmd.set_time.seconds = norm_s[5:0];
      priority if (!is_byte) begin
         push_cmd.kind = CMD_TICK;
      end else if (close) begin
         push_cmd.kind = time_ok ? CMD_SET : CMD_REJECT;
      end else begin
         push_cmd.kind = CMD_BYTE;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         lamp_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         lamp_ff <= lamp_in;
      end
   end

   // Line characters; positions beyond PARSE_LEN are never read
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PARSE_LEN; i++) line_ff[i] <= '0;
      end else if (write_line) begin
         line_ff[pos_ff[LINE_IDX_W-1:0]] <= req_tdata;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sstod_queue.sv =====
// Short command queue between front and back end.
// Depends on sstod_pkg for the entry type and depth.
`default_nettype none

module sstod_queue import sstod_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire cmd_type push_cmd,
   output logic         full,
   output logic         pop_valid,
   output cmd_type      pop_cmd,
   input  wire logic    pop_ready
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   // Pointer and fill bookkeeping
   always_comb begin
      full      = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
      pop_valid = count_ff != '0;
      pop_cmd   = entry_ff[rd_ptr_ff];
      do_push   = push_valid && !full;
      do_pop    = pop_valid && pop_ready;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{PTR_W{1'b0}}, do_push} - {{PTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sstod_back.sv =====
// Back end: keeps the time of day, applies ticks and line sets, holds the
// offset register and the result output register. Depends on sstod_pkg.
`default_nettype none

module sstod_back import sstod_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_data,
   input  wire logic        cmd_valid,
   input  wire cmd_type     cmd,
   output logic             cmd_ready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,  // hours_tens, hours_ones, minutes_tens,
                                        // minutes_ones, seconds_tens, seconds_ones,
                                        // led_bits, zero pad
   output logic [1:0]       rsp_tuser   // time_set_done, time_set_rejected
);

   logic [3:0]  offset_ff;
   tod_type     tod_ff, tod_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   logic        pop, advance;
   tod_type     base;
   logic [3:0]  step;
   logic [6:0]  sum_s;
   logic [5:0]  sum_m;
   logic [4:0]  sum_h;
   logic        carry_s, carry_m;
   tod_type     stepped;
   logic [6:0]  hd, md, sd;

   assign csr_ready = 1'b1;

   // Add a tick or the offset to a normalised time, wrapping at midnight
   always_comb begin
      pop       = cmd_valid && (!rsp_valid_ff || rsp_tready);
      cmd_ready = pop;
      advance   = (cmd.kind == CMD_TICK) || (cmd.kind == CMD_SET);
      base      = (cmd.kind == CMD_SET) ? cmd.set_time : tod_ff;
      step      = (cmd.kind == CMD_SET) ? offset_ff : 4'd1;
      sum_s     = {1'b0, base.seconds} + {3'b000, step};
      carry_s   = sum_s >= 7'(MINUTE_SECONDS);
      stepped.seconds = carry_s ? 6'(sum_s - 7'(MINUTE_SECONDS)) : sum_s[5:0];
      sum_m     = base.minutes + {5'b0, carry_s};
      carry_m   = sum_m >= MINUTE_SECONDS;
      stepped.minutes = carry_m ? sum_m - MINUTE_SECONDS : sum_m;
      sum_h     = base.hours + {4'b0, carry_m};
      stepped.hours = (sum_h >= DAY_HOURS) ? sum_h - DAY_HOURS : sum_h;
      tod_in    = (pop && advance) ? stepped : tod_ff;
   end

   // Result beat built from the time after this command
   always_comb begin
      hd = split_dec({1'b0, tod_in.hours});
      md = split_dec(tod_in.minutes);
      sd = split_dec(tod_in.seconds);
      rsp_data_in = {1'b0, cmd.lamps, sd[3:0], sd[6:4], md[3:0], md[6:4],
                     hd[3:0], hd[5:4]};
      rsp_user_in = {cmd.kind == CMD_REJECT, cmd.kind == CMD_SET};
      priority if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and time state
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= OFFSET_RESET;
         tod_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) offset_ff <= csr_data;
         tod_ff       <= tod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ===== hdl/serial_set_time_of_day_clock.sv =====
// Serial-set 24-hour time-of-day clock with lamp bits.
// Usage:
//   req channel: one beat per item; req_tuser selects a one-second tick (0)
//   or a received serial byte (1) carried in req_tdata.
//   rsp channel: one beat per request beat, in order: the HH:MM:SS digits
//   after the item, the lamp bits, and set-done / set-rejected flags.
//   csr channel: writes the 4-bit seconds offset added to a received time;
//   always ready, write only while no request is in flight.
// Path: a request beat goes through the command queue, then the rsp output register.
// Throughput: one item per cycle while rsp_tready stays high; the front end classifies and
//   parses the line buffer, the back end updates the time once per command.
// Stalls: a two-beat command queue sits between front and back; when the
//   receiver holds rsp_tready low the output register holds its beat, the
//   queue fills and req_tready drops once both queue entries are taken.
// Reset (synchronous): time 00:00:00, empty line, lamps off, offset 2.
// Depends on sstod_pkg, sstod_front, sstod_queue and sstod_back.
`default_nettype none

module serial_set_time_of_day_clock import sstod_pkg::*; #(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [1:0] hours_tens, [5:2] hours_ones,
                                         // [8:6] minutes_tens, [12:9] minutes_ones,
                                         // [15:13] seconds_tens, [19:16] seconds_ones,
                                         // [22:20] led_bits, [23] zero
   output logic [1:0]       rsp_tuser,   // [0] time_set_done, [1] time_set_rejected
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_data     // [3:0] set_offset
);

   logic    push_valid, queue_full, pop_valid, pop_ready;
   cmd_type push_cmd, pop_cmd;

   sstod_front #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   sstod_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   sstod_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd_valid  (pop_valid),
      .cmd        (pop_cmd),
      .cmd_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== test/sstod_reading_checker.sv =====
// Reading checker for the serial-set time-of-day clock testbench.
// Watches the request, result and offset channels, predicts each reading and
// compares it field by field. Depends on sstod_pkg only.
module sstod_reading_checker import sstod_pkg::*; #(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_data,
   output int          mismatch_total,
   output int          readings_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          STORE_DEPTH = LINE_CAPACITY - 1;
   localparam int unsigned DAY_SECONDS = 86400;

   typedef struct {
      logic [1:0] hours_tens;
      logic [3:0] hours_ones;
      logic [2:0] minutes_tens;
      logic [3:0] minutes_ones;
      logic [2:0] seconds_tens;
      logic [3:0] seconds_ones;
      logic [2:0] led_bits;
      logic       set_done;
      logic       set_rejected;
   } clock_reading_type;

   // Predicted clock state
   logic [16:0] day_seconds;
   logic [7:0]  line_chars [STORE_DEPTH];
   int unsigned line_fill;
   logic [2:0]  lamps;
   logic [3:0]  offset;

   clock_reading_type expected_readings[$];
   int mismatches    = 0;
   int readings_seen = 0;

   assign mismatch_total = mismatches;

   // One line per mismatch, and count it
   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [7:0] seen,
                              input logic [7:0] wanted);
      if (seen !== wanted)
         report_mismatch($sformatf("reading %0d %s: got %0h, expected %0h",
                                   readings_seen, name, seen, wanted));
   endtask

   // Advance the predicted clock by one item and return the reading it gives
   function automatic clock_reading_type step_clock(input logic op, input logic [7:0] rx);
      clock_reading_type r;
      int unsigned       hh, mm, ss, value;
      int                d [6];
      int                k;
      logic [7:0]        c;
      bit                valid_time;
      r.set_done     = 1'b0;
      r.set_rejected = 1'b0;
      if (op == OP_TICK) begin
         day_seconds = (day_seconds >= DAY_SECONDS - 1) ? '0 : day_seconds + 1'b1;
      end else if (rx == CHAR_NEWLINE || line_fill >= STORE_DEPTH) begin
         // line closes: digits at HH?MM?SS, separators not checked
         valid_time = (line_fill >= PARSE_LEN);
         for (k = 0; k < 6; k++) begin
            c = line_chars[k + k / 2];
            if (c < CHAR_ZERO || c > CHAR_NINE) valid_time = 1'b0;
            d[k] = int'(c) - int'(CHAR_ZERO);
         end
         value = unsigned'((d[0] * 10 + d[1]) * 3600 + (d[2] * 10 + d[3]) * 60 +
                           d[4] * 10 + d[5]);
         if (valid_time && value >= DAY_SECONDS) valid_time = 1'b0;
         if (valid_time) day_seconds = 17'((value + offset) % DAY_SECONDS);
         line_fill      = 0;
         r.set_done     = valid_time;
         r.set_rejected = !valid_time;
      end else begin
         line_chars[line_fill] = rx;
         line_fill++;
         // lamp command follows the first character of the line
         case (line_chars[0])
            CHAR_RED_ON:    lamps = lamps | LAMP_RED;
            CHAR_RED_OFF:   lamps = lamps & ~LAMP_RED;
            CHAR_GREEN_ON:  lamps = lamps | LAMP_GREEN;
            CHAR_GREEN_OFF: lamps = lamps & ~LAMP_GREEN;
            CHAR_BLUE_ON:   lamps = lamps | LAMP_BLUE;
            CHAR_BLUE_OFF:  lamps = lamps & ~LAMP_BLUE;
            default: ;
         endcase
      end
      hh = day_seconds / 3600;
      mm = (day_seconds / 60) % 60;
      ss = day_seconds % 60;
      r.hours_tens   = 2'(hh / 10);
      r.hours_ones   = 4'(hh % 10);
      r.minutes_tens = 3'(mm / 10);
      r.minutes_ones = 4'(mm % 10);
      r.seconds_tens = 3'(ss / 10);
      r.seconds_ones = 4'(ss % 10);
      r.led_bits     = lamps;
      return r;
   endfunction

   // Offset writes, then new items, then readings leaving the block
   always @(posedge clock) begin : watch_channels
      clock_reading_type want, got;
      if (reset) begin
         day_seconds = '0;
         line_fill   = 0;
         lamps       = '0;
         offset      = OFFSET_RESET;
         foreach (line_chars[i]) line_chars[i] = '0;
         expected_readings.delete();
      end else begin
         if (csr_valid && csr_ready) offset = csr_data;
         if (req_tvalid && req_tready)
            expected_readings.push_back(step_clock(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.hours_tens   = rsp_tdata[1:0];
            got.hours_ones   = rsp_tdata[5:2];
            got.minutes_tens = rsp_tdata[8:6];
            got.minutes_ones = rsp_tdata[12:9];
            got.seconds_tens = rsp_tdata[15:13];
            got.seconds_ones = rsp_tdata[19:16];
            got.led_bits     = rsp_tdata[22:20];
            got.set_done     = rsp_tuser[0];
            got.set_rejected = rsp_tuser[1];
            if (expected_readings.size() == 0) begin
               report_mismatch($sformatf("reading %0d arrived with none expected",
                                         readings_seen));
            end else begin
               want = expected_readings.pop_front();
               check_field("hours_tens", 8'(got.hours_tens), 8'(want.hours_tens));
               check_field("hours_ones", 8'(got.hours_ones), 8'(want.hours_ones));
               check_field("minutes_tens", 8'(got.minutes_tens), 8'(want.minutes_tens));
               check_field("minutes_ones", 8'(got.minutes_ones), 8'(want.minutes_ones));
               check_field("seconds_tens", 8'(got.seconds_tens), 8'(want.seconds_tens));
               check_field("seconds_ones", 8'(got.seconds_ones), 8'(want.seconds_ones));
               check_field("led_bits", 8'(got.led_bits), 8'(want.led_bits));
               check_field("time_set_done", 8'(got.set_done), 8'(want.set_done));
               check_field("time_set_rejected", 8'(got.set_rejected),
                           8'(want.set_rejected));
            end
            readings_seen++;
         end
      end
      readings_outstanding <= expected_readings.size();
   end

endmodule

// ===== test/tb.sv =====
// Top of the serial-set time-of-day clock testbench: clock, reset, stimulus
// and verdict. Needs serial_set_time_of_day_clock, sstod_pkg and the
// sstod_reading_checker module.
module tb import sstod_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_CAPACITY = LINE_CAPACITY_DEFAULT;

   typedef logic [7:0] text_type[$];

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] rx_byte
   logic        req_tuser  = OP_TICK;   // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;   // [1:0] hours_tens .. [22:20] led_bits, [23] zero
   logic [1:0]  rsp_tuser;   // [0] time_set_done, [1] time_set_rejected
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_data   = '0;   // [3:0] set_offset

   int mismatch_total;
   int readings_outstanding;
   int beats_offered  = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_seen      = 0;
   int hold_left      = 0;

   serial_set_time_of_day_clock #(.LINE_CAPACITY(LINE_CAPACITY)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   sstod_reading_checker #(.LINE_CAPACITY(LINE_CAPACITY)) u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_tvalid           (req_tvalid),
      .req_tready           (req_tready),
      .req_tdata            (req_tdata),
      .req_tuser            (req_tuser),
      .rsp_tvalid           (rsp_tvalid),
      .rsp_tready           (rsp_tready),
      .rsp_tdata            (rsp_tdata),
      .rsp_tuser            (rsp_tuser),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data),
      .mismatch_total       (mismatch_total),
      .readings_outstanding (readings_outstanding)
   );

   always #6 clock = ~clock;

   // Result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_seen != hold_requests) begin
         hold_seen  = hold_requests;
         hold_left  = 60;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= unsigned'(recv_stall_pct));
      end
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // One beat on the request channel, with random idle cycles ahead of it
   task automatic offer_beat(input logic op, input logic [7:0] data);
      while ($urandom_range(99) < unsigned'(send_idle_pct)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      beats_offered++;
   endtask

   task automatic offer_text(input text_type chars);
      foreach (chars[i]) offer_beat(OP_BYTE, chars[i]);
   endtask

   // Hold the request side idle until every reading has come back
   task automatic drain_readings();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (readings_outstanding != 0);
   endtask

   task automatic write_offset(input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic text_type text_of(input string s);
      text_type t;
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      return t;
   endfunction

   function automatic logic [7:0] any_char_but_newline();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == CHAR_NEWLINE);
      return c;
   endfunction

   // HH?MM?SS with random separators; pairs up to 99 give any digit pattern
   function automatic text_type time_text(input int hh, input int mm, input int ss);
      text_type t;
      t.push_back(CHAR_ZERO + 8'(hh / 10));
      t.push_back(CHAR_ZERO + 8'(hh % 10));
      t.push_back(any_char_but_newline());
      t.push_back(CHAR_ZERO + 8'(mm / 10));
      t.push_back(CHAR_ZERO + 8'(mm % 10));
      t.push_back(any_char_but_newline());
      t.push_back(CHAR_ZERO + 8'(ss / 10));
      t.push_back(CHAR_ZERO + 8'(ss % 10));
      return t;
   endfunction

   // Mostly well-formed lines with random content, the rest noise
   task automatic random_traffic(input int quota);
      int         start_count, pick, n, k;
      logic [7:0] c;
      text_type   line;
      start_count = beats_offered;
      while (beats_offered - start_count < quota) begin
         pick = $urandom_range(99);
         line = {};
         if (pick < 35) begin
            // valid time, now and then close to midnight
            if ($urandom_range(4) == 0)
               line = time_text(23, 59, $urandom_range(59, 50));
            else
               line = time_text($urandom_range(23), $urandom_range(59), $urandom_range(59));
            if ($urandom_range(5) == 0) begin
               // fill the buffer; the next byte closes and is dropped
               line.push_back(any_char_but_newline());
               line.push_back(8'($urandom_range(255)));
            end else begin
               line.push_back(CHAR_NEWLINE);
            end
         end else if (pick < 50) begin
            n = $urandom_range(6, 1);
            repeat (n) offer_beat(OP_TICK, 8'($urandom_range(255)));
         end else if (pick < 60) begin
            // lamp line
            case ($urandom_range(6))
               0: line.push_back(CHAR_RED_ON);
               1: line.push_back(CHAR_RED_OFF);
               2: line.push_back(CHAR_GREEN_ON);
               3: line.push_back(CHAR_GREEN_OFF);
               4: line.push_back(CHAR_BLUE_ON);
               5: line.push_back(CHAR_BLUE_OFF);
               default: line.push_back(any_char_but_newline());
            endcase
            n = $urandom_range(9);
            repeat (n) line.push_back(any_char_but_newline());
            line.push_back(CHAR_NEWLINE);
         end else if (pick < 70) begin
            // any digits: mostly out of range
            line = time_text($urandom_range(99), $urandom_range(99), $urandom_range(99));
            line.push_back(CHAR_NEWLINE);
         end else if (pick < 80) begin
            // valid time with one digit position spoilt
            line = time_text($urandom_range(23), $urandom_range(59), $urandom_range(59));
            k = $urandom_range(5);
            do c = any_char_but_newline(); while (c >= CHAR_ZERO && c <= CHAR_NINE);
            line[k + k / 2] = c;
            line.push_back(CHAR_NEWLINE);
         end else if (pick < 90) begin
            n = $urandom_range(7);
            repeat (n) line.push_back(any_char_but_newline());
            line.push_back(CHAR_NEWLINE);
         end else begin
            n = $urandom_range(12, 1);
            repeat (n) offer_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
         end
         offer_text(line);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: midnight wrap, lamp line, extreme bytes, full buffer
      offer_text(text_of("23:59:57\n"));
      offer_beat(OP_TICK, 8'hFF);
      offer_text(text_of("G\n"));
      offer_text('{8'h00, 8'hFF, CHAR_NEWLINE});
      offer_text(text_of("12:34:567Q"));

      // No idling, largest offset; long result hold-off in the middle
      drain_readings();
      write_offset(4'd15);
      random_traffic(100);
      hold_requests++;
      repeat (20) offer_beat(OP_TICK, 8'($urandom_range(255)));
      drain_readings();
      random_traffic(150);

      // Sender idles
      drain_readings();
      write_offset(4'd0);
      send_idle_pct = 67;
      random_traffic(250);

      // Receiver stalls
      drain_readings();
      write_offset(4'($urandom_range(15)));
      send_idle_pct  = 0;
      recv_stall_pct = 67;
      random_traffic(250);

      // Both sides
      drain_readings();
      write_offset(4'($urandom_range(14, 1)));
      send_idle_pct  = 32;
      recv_stall_pct = 32;
      random_traffic(250);

      drain_readings();
      repeat (10) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
